/* rtl/indexed_list_insert_delete_assert.svh */
// assertion macros used by the rtl
`ifndef INDEXED_LIST_INSERT_DELETE_ASSERT_SVH
`define INDEXED_LIST_INSERT_DELETE_ASSERT_SVH

// same-cycle implication
`define ILID_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ILID_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/ilid_pkg.sv */
`default_nettype none
package ilid_pkg;

   localparam int CAPACITY_DEF = 64;

   localparam int CMD_W    = 3;
   localparam int POS_W    = 7;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;
   localparam int IDX_W    = 6;
   localparam int COUNT_W  = 7;

   localparam logic KIND_STATUS = 1'b0;
   localparam logic KIND_ELEM   = 1'b1;

   typedef enum logic [CMD_W-1:0] {
      CMD_CLEAR  = 3'd0,
      CMD_APPEND = 3'd1,
      CMD_DUMP   = 3'd2,
      CMD_INSERT = 3'd3,
      CMD_UPDATE = 3'd4,
      CMD_DELETE = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK     = 2'd0,
      STAT_BADPOS = 2'd1,
      STAT_FULL   = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SHIFT_UP,
      S_PUT,
      S_SHIFT_DN,
      S_DUMP_RD,
      S_DUMP_LD,
      S_REPLY
   } state_type;

   // one result word handed to the output register
   typedef struct packed {
      logic                       valid;
      logic                       kind;
      status_type                 status;
      logic signed [VALUE_W-1:0]  element;
      logic [IDX_W-1:0]           element_index;
      logic [COUNT_W-1:0]         entry_count;
      logic                       last;
   } rsp_load_type;

endpackage
`default_nettype wire

/* rtl/indexed_list_insert_delete.sv */
// channel   dir   tdata (lsb first)                                    tuser   tlast
// req_      in    position[6:0] value[38:7] pad[39]                    cmd     -
// rsp_      out   status[1:0] element[33:2] element_index[39:34]       kind    last
//                 entry_count[46:40] pad[47]
//
// one word in at a time; ready only while the sequencer is idle.
// clear, append, update and rejected edits finish in idle and go on to the status word.
// insert moves one entry a cycle through the ram, then writes the new value.
// delete shifts the entries above the position down; dump reads one entry at a time, waiting on result stalls.
// reset clears the count, the state and the result valid; the ram is not swept.
// a held result waits in the output register while the next word is accepted.
`default_nettype none
module indexed_list_insert_delete
   import ilid_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [39:0] req_tdata,   // position, value
   input  wire logic [2:0]  req_tuser,   // cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [47:0]      rsp_tdata,   // status, element, element_index, entry_count
   output logic             rsp_tuser,   // kind
   output logic             rsp_tlast
);

   localparam int AW = $clog2(CAPACITY);

   rsp_load_type        load;
   rsp_load_type        rsp_ff;
   logic                rsp_valid_ff;
   logic                slot_free;
   logic                ram_wr_en, ram_rd_en;
   logic [AW-1:0]       ram_wr_addr, ram_rd_addr;
   logic [VALUE_W-1:0]  ram_wr_data, ram_rd_data;

   assign slot_free = !rsp_valid_ff || rsp_tready;

   ilid_seq #(
      .CAPACITY (CAPACITY)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_tvalid),
      .req_ready   (req_tready),
      .req_cmd     (req_tuser),
      .req_pos     (req_tdata[POS_W-1:0]),
      .req_value   (req_tdata[POS_W+VALUE_W-1:POS_W]),
      .slot_free   (slot_free),
      .load        (load),
      .ram_wr_en   (ram_wr_en),
      .ram_wr_addr (ram_wr_addr),
      .ram_wr_data (ram_wr_data),
      .ram_rd_en   (ram_rd_en),
      .ram_rd_addr (ram_rd_addr),
      .ram_rd_data (ram_rd_data)
   );

   ilid_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load.valid) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (load.valid) begin
         rsp_ff <= load;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last;
   assign rsp_tdata  = {1'b0, rsp_ff.entry_count, rsp_ff.element_index,
                        rsp_ff.element, rsp_ff.status};

`include "indexed_list_insert_delete_assert.svh"

   `ILID_ASSERT_NOW(a_no_overwrite, clock, reset, load.valid, slot_free, "result word overwritten")
   `ILID_ASSERT_NOW(a_ram_no_clash, clock, reset, ram_wr_en && ram_rd_en, ram_wr_addr != ram_rd_addr, "ram read and write hit one entry")
   `ILID_ASSERT_NOW(a_count_bound, clock, reset, rsp_tvalid, rsp_ff.entry_count <= COUNT_W'(CAPACITY), "count above capacity")
   `ILID_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "second word taken while busy")

endmodule
`default_nettype wire

/* rtl/ilid_ram.sv */
`default_nettype none
module ilid_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* rtl/ilid_seq.sv */
`default_nettype none
module ilid_seq
   import ilid_pkg::*;
#(
   parameter int CAPACITY = CAPACITY_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic [CMD_W-1:0]            req_cmd,
   input  wire logic [POS_W-1:0]            req_pos,
   input  wire logic signed [VALUE_W-1:0]   req_value,
   input  wire logic                        slot_free,
   output rsp_load_type                     load,
   output logic                             ram_wr_en,
   output logic [$clog2(CAPACITY)-1:0]      ram_wr_addr,
   output logic [VALUE_W-1:0]               ram_wr_data,
   output logic                             ram_rd_en,
   output logic [$clog2(CAPACITY)-1:0]      ram_rd_addr,
   input  wire logic [VALUE_W-1:0]          ram_rd_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAPACITY);

   state_type                  state_ff, state_in;
   status_type                 status_ff, status_in;
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic [COUNT_W-1:0]         cursor_ff, cursor_in;
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic signed [VALUE_W-1:0]  value_ff, value_in;

   logic [COUNT_W-1:0] count_inc, count_dec;
   logic [COUNT_W-1:0] cursor_inc, cursor_inc2, cursor_dec, cursor_dec2;
   logic [POS_W-1:0]   pos_inc;
   logic               full;

   assign count_inc   = count_ff + 1'b1;
   assign count_dec   = count_ff - 1'b1;
   assign cursor_inc  = cursor_ff + 1'b1;
   assign cursor_inc2 = cursor_ff + 2'd2;
   assign cursor_dec  = cursor_ff - 1'b1;
   assign cursor_dec2 = cursor_ff - 2'd2;
   assign pos_inc     = req_pos + 1'b1;
   assign full        = count_ff >= CAP_COUNT;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      status_ff <= status_in;
      cursor_ff <= cursor_in;
      pos_ff    <= pos_in;
      value_ff  <= value_in;
   end

   always_comb begin
      state_in    = state_ff;
      status_in   = status_ff;
      count_in    = count_ff;
      cursor_in   = cursor_ff;
      pos_in      = pos_ff;
      value_in    = value_ff;
      req_ready   = (state_ff == S_IDLE);
      ram_wr_en   = 1'b0;
      ram_wr_addr = cursor_ff[AW-1:0];
      ram_wr_data = ram_rd_data;
      ram_rd_en   = 1'b0;
      ram_rd_addr = cursor_ff[AW-1:0];
      load        = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               pos_in    = req_pos;
               value_in  = req_value;
               status_in = STAT_OK;
               state_in  = S_REPLY;
               case (cmd_type'(req_cmd))
                  CMD_CLEAR: begin
                     count_in = '0;
                  end
                  CMD_APPEND: begin
                     if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_ff[AW-1:0];
                        ram_wr_data = req_value;
                        count_in    = count_inc;
                     end
                  end
                  CMD_DUMP: begin
                     if (count_ff != '0) begin
                        cursor_in = '0;
                        state_in  = S_DUMP_RD;
                     end
                  end
                  CMD_INSERT: begin
                     if (req_pos > count_ff) begin
                        status_in = STAT_BADPOS;
                     end else if (full) begin
                        status_in = STAT_FULL;
                     end else if (req_pos == count_ff) begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = count_ff[AW-1:0];
                        ram_wr_data = req_value;
                        count_in    = count_inc;
                     end else begin
                        // top entry moves first, walking down to the slot
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = count_dec[AW-1:0];
                        cursor_in   = count_ff;
                        state_in    = S_SHIFT_UP;
                     end
                  end
                  CMD_UPDATE: begin
                     if (req_pos >= count_ff) begin
                        status_in = STAT_BADPOS;
                     end else begin
                        ram_wr_en   = 1'b1;
                        ram_wr_addr = req_pos[AW-1:0];
                        ram_wr_data = req_value;
                     end
                  end
                  CMD_DELETE: begin
                     if (req_pos >= count_ff) begin
                        status_in = STAT_BADPOS;
                     end else if (req_pos == count_dec) begin
                        count_in = count_dec;
                     end else begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = pos_inc[AW-1:0];
                        cursor_in   = req_pos;
                        state_in    = S_SHIFT_DN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end

         S_SHIFT_UP: begin
            // write entry from last read, read the next one lower down
            ram_wr_en = 1'b1;
            cursor_in = cursor_dec;
            if (cursor_dec > pos_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cursor_dec2[AW-1:0];
            end else begin
               state_in = S_PUT;
            end
         end

         S_PUT: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = pos_ff[AW-1:0];
            ram_wr_data = value_ff;
            count_in    = count_inc;
            state_in    = S_REPLY;
         end

         S_SHIFT_DN: begin
            ram_wr_en = 1'b1;
            cursor_in = cursor_inc;
            if (cursor_inc2 < count_ff) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cursor_inc2[AW-1:0];
            end else begin
               count_in = count_dec;
               state_in = S_REPLY;
            end
         end

         S_DUMP_RD: begin
            // only read once the output register can take the word
            if (slot_free) begin
               ram_rd_en = 1'b1;
               state_in  = S_DUMP_LD;
            end
         end

         S_DUMP_LD: begin
            load.valid         = 1'b1;
            load.kind          = KIND_ELEM;
            load.status        = STAT_OK;
            load.element       = ram_rd_data;
            load.element_index = cursor_ff[IDX_W-1:0];
            load.entry_count   = count_ff;
            load.last          = (cursor_inc == count_ff);
            if (cursor_inc == count_ff) begin
               state_in = S_IDLE;
            end else begin
               cursor_in = cursor_inc;
               state_in  = S_DUMP_RD;
            end
         end

         S_REPLY: begin
            if (slot_free) begin
               load.valid       = 1'b1;
               load.kind        = KIND_STATUS;
               load.status      = status_ff;
               load.entry_count = count_ff;
               load.last        = 1'b1;
               state_in         = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

/* test/tb.sv */
module tb
   import ilid_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LIST_CAP       = CAPACITY_DEF;
   localparam int STIM_ITEMS     = 410;
   localparam int CALM_ITEMS     = 40;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int TAIL_CYCLES    = 200;
   localparam int PRINT_CAP      = 50;

   // command codes the block leaves unused
   localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

   typedef struct {
      logic [CMD_W-1:0]   cmd;
      logic [POS_W-1:0]   pos;
      logic [VALUE_W-1:0] val;
      bit                 drain;   // hold off until every expected word is back
   } list_cmd_type;

   typedef struct {
      logic                kind;
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  element;
      logic [IDX_W-1:0]    idx;
      logic [COUNT_W-1:0]  cnt;
      logic                last;
   } list_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;   // position[6:0], value[38:7], pad[39]
   logic [2:0]  req_tuser = '0;   // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;        // status[1:0], element[33:2], element_index[39:34],
                                  // entry_count[46:40], pad[47]
   logic        rsp_tuser;        // kind
   logic        rsp_tlast;

   list_cmd_type pending_cmds[$];
   list_rsp_type expected_rsps[$];

   // predicted list contents
   logic [VALUE_W-1:0] list_mem [LIST_CAP];
   int                 list_len = 0;

   int  gen_len = 0;   // count as the stimulus generator sees it
   int  total_cmds = 0;
   int  accepted_cmds = 0;
   int  idle_cycles = 0;
   int  mismatches = 0;
   bit  req_taken = 1'b0;
   bit  timed_out = 1'b0;
   int  send_gap = 0;
   int  hold_gap = 0;
   bit  idle_mode_req = 1'b1;
   bit  idle_mode_rsp = 1'b1;

   indexed_list_insert_delete u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= PRINT_CAP) begin
         $display("%0t mismatch: %s", $realtime, msg);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
      end
   endtask

   task automatic push_status(input status_type st);
      list_rsp_type r;
      r.kind    = KIND_STATUS;
      r.status  = st;
      r.element = '0;
      r.idx     = '0;
      r.cnt     = list_len[COUNT_W-1:0];
      r.last    = 1'b1;
      expected_rsps.push_back(r);
   endtask

   // apply one accepted command word to the predicted list
   task automatic apply_command(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                                input logic [VALUE_W-1:0] val);
      status_type   st;
      list_rsp_type r;
      int           i;
      st = STAT_OK;
      case (cmd)
         CMD_CLEAR: begin
            list_len = 0;
         end
         CMD_APPEND: begin
            if (list_len >= LIST_CAP) begin
               st = STAT_FULL;
            end else begin
               list_mem[list_len] = val;
               list_len++;
            end
         end
         CMD_DUMP: begin
            if (list_len != 0) begin
               for (i = 0; i < list_len; i++) begin
                  r.kind    = KIND_ELEM;
                  r.status  = STAT_OK;
                  r.element = list_mem[i];
                  r.idx     = i[IDX_W-1:0];
                  r.cnt     = list_len[COUNT_W-1:0];
                  r.last    = (i == list_len - 1);
                  expected_rsps.push_back(r);
               end
               return;
            end
         end
         CMD_INSERT: begin
            if (int'(pos) > list_len) begin
               st = STAT_BADPOS;
            end else if (list_len >= LIST_CAP) begin
               st = STAT_FULL;
            end else begin
               for (i = list_len; i > int'(pos); i--) begin
                  list_mem[i] = list_mem[i-1];
               end
               list_mem[pos] = val;
               list_len++;
            end
         end
         CMD_UPDATE: begin
            if (int'(pos) >= list_len) begin
               st = STAT_BADPOS;
            end else begin
               list_mem[pos] = val;
            end
         end
         CMD_DELETE: begin
            if (int'(pos) >= list_len) begin
               st = STAT_BADPOS;
            end else begin
               for (i = int'(pos); i + 1 < list_len; i++) begin
                  list_mem[i] = list_mem[i+1];
               end
               list_len--;
            end
         end
         default: begin
         end
      endcase
      push_status(st);
   endtask

   // queue a command and follow its effect on the count
   task automatic push_cmd(input logic [CMD_W-1:0] cmd, input int pos,
                           input logic [VALUE_W-1:0] val, input bit drain);
      list_cmd_type c;
      c.cmd   = cmd;
      c.pos   = pos[POS_W-1:0];
      c.val   = val;
      c.drain = drain;
      pending_cmds.push_back(c);
      case (cmd)
         CMD_CLEAR:  gen_len = 0;
         CMD_APPEND: if (gen_len < LIST_CAP) gen_len++;
         CMD_INSERT: if (pos <= gen_len && gen_len < LIST_CAP) gen_len++;
         CMD_DELETE: if (pos < gen_len) gen_len--;
         default: begin
         end
      endcase
   endtask

   function automatic logic [VALUE_W-1:0] pick_value();
      logic [VALUE_W-1:0] v;
      v = $urandom;
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: v = 32'h8000_0000;
            1: v = 32'h7fff_ffff;
            2: v = 32'h0000_0000;
            default: v = 32'hffff_ffff;
         endcase
      end
      return v;
   endfunction

   // sample both channels and keep the prediction in step
   always @(posedge clock) begin : watch_ports
      list_rsp_type got;
      list_rsp_type want;
      bit           rsp_taken;
      req_taken = 1'b0;
      rsp_taken = 1'b0;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         rsp_taken = rsp_tvalid && rsp_tready;
         req_taken = req_tvalid && req_tready;
         if (rsp_taken) begin
            got.kind    = rsp_tuser;
            got.status  = rsp_tdata[1:0];
            got.element = rsp_tdata[33:2];
            got.idx     = rsp_tdata[39:34];
            got.cnt     = rsp_tdata[46:40];
            got.last    = rsp_tlast;
            if (expected_rsps.size() == 0) begin
               report_mismatch("result word with nothing expected");
            end else begin
               want = expected_rsps.pop_front();
               check_field("kind", 32'(got.kind), 32'(want.kind));
               check_field("status", 32'(got.status), 32'(want.status));
               check_field("element", got.element, want.element);
               check_field("element_index", 32'(got.idx), 32'(want.idx));
               check_field("entry_count", 32'(got.cnt), 32'(want.cnt));
               check_field("last", 32'(got.last), 32'(want.last));
            end
         end
         if (req_taken) begin
            accepted_cmds++;
            apply_command(req_tuser, req_tdata[6:0], req_tdata[38:7]);
         end
         if (req_taken || rsp_taken) idle_cycles = 0;
         else idle_cycles++;
      end
   end

   always @(negedge clock) begin : drive_req
      list_cmd_type item;
      logic         nxt_valid;
      bit           calm;
      nxt_valid = req_tvalid;
      calm = (total_cmds - accepted_cmds) < CALM_ITEMS;
      if (reset) begin
         nxt_valid = 1'b0;
      end else if (!req_tvalid || req_taken) begin
         nxt_valid = 1'b0;
         if (idle_mode_req && !calm && send_gap == 0 && $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(1, 12);
         end
         if (send_gap != 0) begin
            send_gap--;
         end else if (pending_cmds.size() != 0 &&
                      (!pending_cmds[0].drain || expected_rsps.size() == 0)) begin
            item = pending_cmds.pop_front();
            nxt_valid = 1'b1;
            req_tdata <= {1'b0, item.val, item.pos};
            req_tuser <= item.cmd;
         end
         if ($urandom_range(0, 63) == 0) idle_mode_req = !idle_mode_req;
      end
      req_tvalid <= nxt_valid;
   end

   always @(negedge clock) begin : drive_rsp_ready
      bit calm;
      calm = (total_cmds - accepted_cmds) < CALM_ITEMS;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (idle_mode_rsp && !calm && hold_gap == 0 && $urandom_range(0, 5) == 0) begin
            hold_gap = $urandom_range(1, 12);
         end
         if (hold_gap != 0) begin
            hold_gap--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
         if ($urandom_range(0, 63) == 0) idle_mode_rsp = !idle_mode_rsp;
      end
   end

   initial begin
      int r;
      int p;
      logic [CMD_W-1:0] c;

      // empty-list and edge positions
      push_cmd(CMD_DUMP, 0, 32'h0, 0);
      push_cmd(CMD_DELETE, 0, 32'h0, 0);
      push_cmd(CMD_UPDATE, 0, 32'hffff_ffff, 0);
      push_cmd(CMD_INSERT, 1, 32'h1, 0);
      push_cmd(CMD_INSERT, 0, 32'h8000_0000, 0);
      push_cmd(CMD_APPEND, 127, 32'h7fff_ffff, 0);
      push_cmd(CMD_APPEND, 0, 32'hffff_ffff, 0);
      push_cmd(CMD_APPEND, 0, 32'h0, 0);
      push_cmd(CMD_INSERT, 4, 32'h1, 0);
      push_cmd(CMD_INSERT, 2, 32'h5555_5555, 0);
      push_cmd(CMD_UPDATE, 5, 32'haaaa_aaaa, 0);
      push_cmd(CMD_UPDATE, 6, 32'h1234_5678, 0);
      push_cmd(CMD_DELETE, 6, 32'h0, 0);
      push_cmd(CMD_DELETE, 0, 32'h0, 0);
      push_cmd(CMD_DELETE, 4, 32'h0, 0);
      push_cmd(CMD_SPARE6, 127, 32'hffff_ffff, 0);
      push_cmd(CMD_SPARE7, 7'h55, 32'h0, 0);
      push_cmd(CMD_INSERT, 127, 32'h7fff_ffff, 0);
      push_cmd(CMD_DUMP, 127, 32'hffff_ffff, 0);
      push_cmd(CMD_UPDATE, 0, 32'h8000_0000, 0);
      push_cmd(CMD_DUMP, 0, 32'h0, 0);
      push_cmd(CMD_CLEAR, 127, 32'hffff_ffff, 0);
      push_cmd(CMD_DUMP, 0, 32'h0, 0);
      push_cmd(CMD_APPEND, 0, 32'h1234_5678, 0);
      push_cmd(CMD_DELETE, 0, 32'h0, 0);

      // fill to capacity, then push on the full list
      push_cmd(CMD_CLEAR, $urandom_range(0, 127), pick_value(), 0);
      while (gen_len < LIST_CAP) begin
         if ($urandom_range(0, 1) == 0) begin
            push_cmd(CMD_APPEND, $urandom_range(0, 127), pick_value(), 0);
         end else begin
            push_cmd(CMD_INSERT, $urandom_range(0, gen_len), pick_value(), 0);
         end
      end
      push_cmd(CMD_APPEND, 0, pick_value(), 0);
      push_cmd(CMD_INSERT, LIST_CAP, pick_value(), 0);
      push_cmd(CMD_INSERT, 0, pick_value(), 0);
      push_cmd(CMD_INSERT, LIST_CAP + 1, pick_value(), 0);
      push_cmd(CMD_INSERT, 127, pick_value(), 0);
      push_cmd(CMD_UPDATE, LIST_CAP - 1, pick_value(), 0);
      push_cmd(CMD_UPDATE, LIST_CAP, pick_value(), 0);
      push_cmd(CMD_DUMP, $urandom_range(0, 127), pick_value(), 1);
      push_cmd(CMD_DELETE, LIST_CAP - 1, pick_value(), 0);
      push_cmd(CMD_DELETE, 0, pick_value(), 0);
      push_cmd(CMD_INSERT, 0, pick_value(), 0);
      push_cmd(CMD_DUMP, 0, pick_value(), 0);

      // mostly valid edits with random content, some stray positions and codes
      while (pending_cmds.size() < STIM_ITEMS) begin
         r = $urandom_range(0, 99);
         if (r < 4 || (gen_len > 48 && r < 8)) c = CMD_CLEAR;
         else if (r < 22) c = CMD_APPEND;
         else if (r < 30) c = CMD_DUMP;
         else if (r < 50) c = CMD_INSERT;
         else if (r < 68) c = CMD_UPDATE;
         else if (r < 88) c = CMD_DELETE;
         else if (r < 92) c = CMD_W'($urandom_range(6, 7));
         else c = CMD_W'($urandom_range(0, 7));
         if ($urandom_range(0, 4) == 0) begin
            p = $urandom_range(0, 127);
         end else if (c == CMD_INSERT) begin
            p = $urandom_range(0, gen_len);
         end else if (gen_len > 0) begin
            p = $urandom_range(0, gen_len - 1);
         end else begin
            p = 0;
         end
         push_cmd(c, p, pick_value(), $urandom_range(0, 39) == 0);
      end
      total_cmds = pending_cmds.size();

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (!timed_out && (accepted_cmds < total_cmds || expected_rsps.size() != 0)) begin
         @(negedge clock);
         if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
      end
      if (!timed_out) begin
         repeat (TAIL_CYCLES) @(negedge clock);
      end
      if (expected_rsps.size() != 0) begin
         report_mismatch($sformatf("%0d expected result words never came",
                                   expected_rsps.size()));
      end
      if (!timed_out && mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
